>>> rtl/odc_pkg.sv
// Shared types, register codes and elaboration-time helpers for the directory checker.
`default_nettype none
package odc_pkg;

	localparam int unsigned WORD_W = 32;

	// Entry status codes, first error latched per directory
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ALIGN  = 2'd1,
		ST_LAYOUT = 2'd2,
		ST_BOUNDS = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PACKED_AREA_LENGTH = 2'd0,
		REG_MINIMUM_LENGTH     = 2'd1,
		REG_EXACT_MODE         = 2'd2,
		REG_EXACT_LENGTH       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [WORD_W-1:0] packed_area_length;
		logic [WORD_W-1:0] minimum_length;
		logic              exact_mode;
		logic [WORD_W-1:0] exact_length;
	} cfg_t;

	// Stateless check results for one entry
	typedef struct packed {
		logic              align_bad;
		logic              length_bad;
		logic              bounds_bad;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] entry_end;
		logic              last;
	} check_t;

	// Count low zero bits of a nonzero constant
	function automatic int unsigned trailing_zeros(input int unsigned v);
		int unsigned n;
		int unsigned x;
		n = 0;
		x = v;
		for (int i = 0; i < 31; i++) begin
			if (x != 0 && (x & 1) == 0) begin
				x = x >> 1;
				n++;
			end
		end
		return n;
	endfunction

	// Inverse of an odd constant modulo 2^32 by Newton iteration
	function automatic logic [WORD_W-1:0] odd_inverse(input logic [WORD_W-1:0] m);
		logic [WORD_W-1:0] x;
		x = m;
		for (int i = 0; i < 5; i++) begin
			x = x * (32'd2 - m * x);
		end
		return x;
	endfunction

endpackage
`default_nettype wire

>>> rtl/odc_precheck.sv
// Input register, stateless entry checks (alignment, length, bounds) and check result register.
`default_nettype none
module odc_precheck #(
	parameter int unsigned ALIGN_BYTES = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire odc_pkg::cfg_t             cfg,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [odc_pkg::WORD_W-1:0] in_offset,
	input  wire logic [odc_pkg::WORD_W-1:0] in_length,
	input  wire logic                      in_last,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output odc_pkg::check_t                out_check
);
	import odc_pkg::*;

	// Divisibility by ALIGN_BYTES = 2^TZ * ODD: low bits clear, and the odd
	// part tested by multiplying with its modular inverse.
	localparam int unsigned       ALIGN_TZ    = trailing_zeros(ALIGN_BYTES);
	localparam logic [WORD_W-1:0] ALIGN_ODD   = WORD_W'(ALIGN_BYTES >> ALIGN_TZ);
	localparam logic [WORD_W-1:0] ALIGN_INV   = odd_inverse(ALIGN_ODD);
	localparam logic [WORD_W-1:0] ALIGN_LIMIT = {WORD_W{1'b1}} / ALIGN_ODD;
	localparam logic [WORD_W-1:0] ALIGN_MASK  = (WORD_W'(1) << ALIGN_TZ) - WORD_W'(1);

	logic              valid_s1;
	logic [WORD_W-1:0] offset_s1;
	logic [WORD_W-1:0] length_s1;
	logic              last_s1;
	logic              valid_s2;
	check_t            check_s2;
	logic              load_s1;
	logic              load_s2;
	logic [WORD_W-1:0] align_prod;
	logic [WORD_W:0]   end_sum;
	check_t            check_d;

	// Stage enables: a stage loads when empty or when it drains this cycle
	assign load_s2  = !valid_s2 || out_ready;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			offset_s1 <= in_offset;
			length_s1 <= in_length;
			last_s1   <= in_last;
		end
	end

	// Stateless checks on the registered entry
	always_comb begin
		align_prod         = WORD_W'(offset_s1 * ALIGN_INV);
		end_sum            = {1'b0, offset_s1} + {1'b0, length_s1};
		check_d.align_bad  = ((offset_s1 & ALIGN_MASK) != '0) || (align_prod > ALIGN_LIMIT);
		check_d.length_bad = cfg.exact_mode ? (length_s1 != cfg.exact_length)
		                                    : (length_s1 < cfg.minimum_length);
		check_d.bounds_bad = end_sum > {1'b0, cfg.packed_area_length};
		check_d.offset     = offset_s1;
		check_d.entry_end  = end_sum[WORD_W-1:0];
		check_d.last       = last_s1;
	end

	// Check result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			check_s2 <= check_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_check = check_s2;

endmodule
`default_nettype wire

>>> rtl/ordered_directory_checker.sv
// Top level of the ordered directory checker: config registers, ordering state, result register.
// Usage:
//   Directory entries arrive on the s_axis channel, one per transfer: tdata holds
//   entry_offset in bits 31:0 and entry_length in bits 63:32, tlast marks the
//   final entry of a directory. Each entry yields one result transfer on m_axis:
//   tdata[1:0] is the status so far (0 ok, 1 bad alignment, 2 bad layout,
//   3 out of bounds), tlast repeats the entry's last mark.
//   The first error of a directory is latched; later entries of that directory
//   are not checked and report the latched status. After the last entry the
//   ordering state and the latched error clear.
//   The path from input transfer to result valid runs through the input register,
//   check register and result register. Throughput is one entry per cycle while
//   m_axis accepts results; the ordering compare against the previous entry's
//   end is combinational between the check register and the result register,
//   which sets that rate.
//   Each stage holds its item while the next one is full, so a stalled m_axis
//   stops intake only once all three stages are occupied.
//   Configuration goes through cfg_we/cfg_index/cfg_data, one register per
//   cycle; the user must write it only while no entry is in flight (not enforced).
//   Reset clears all configuration registers, the ordering state and the
//   pipeline valids.
`default_nettype none
module ordered_directory_checker #(
	parameter int unsigned ALIGN_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// Entry input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [31:0] entry_offset, [63:32] entry_length
	input  wire logic        s_axis_tlast,  // last_entry
	// Result output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [1:0] status, [7:2] zero
	output logic             m_axis_tlast   // done_res
);
	import odc_pkg::*;

	cfg_t              cfg_q;
	logic              chk_valid;
	logic              chk_ready;
	check_t            chk;
	logic              out_valid_q;
	status_t           status_q;
	logic              last_q;
	logic [WORD_W-1:0] prev_end_q;
	logic              seen_q;
	status_t           latched_q;
	logic              load_out;
	status_t           status_d;
	logic              order_bad;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PACKED_AREA_LENGTH: cfg_q.packed_area_length <= cfg_data;
				REG_MINIMUM_LENGTH:     cfg_q.minimum_length     <= cfg_data;
				REG_EXACT_MODE:         cfg_q.exact_mode         <= cfg_data[0];
				REG_EXACT_LENGTH:       cfg_q.exact_length       <= cfg_data;
				default: ;
			endcase
		end
	end

	odc_precheck #(
		.ALIGN_BYTES(ALIGN_BYTES)
	) u_precheck (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_offset (s_axis_tdata[31:0]),
		.in_length (s_axis_tdata[63:32]),
		.in_last   (s_axis_tlast),
		.out_valid (chk_valid),
		.out_ready (chk_ready),
		.out_check (chk)
	);

	assign chk_ready = !out_valid_q || m_axis_tready;
	assign load_out  = chk_valid && chk_ready;

	// Pick the first failing check, in priority order
	always_comb begin
		order_bad = seen_q && (chk.offset < prev_end_q);
		status_d  = latched_q;
		if (latched_q == ST_OK) begin
			if (chk.align_bad) begin
				status_d = ST_ALIGN;
			end else if (chk.length_bad) begin
				status_d = ST_LAYOUT;
			end else if (chk.bounds_bad) begin
				status_d = ST_BOUNDS;
			end else if (order_bad) begin
				status_d = ST_LAYOUT;
			end
		end
	end

	// Directory state: latch the first error, advance the end, clear after last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_end_q <= '0;
			seen_q     <= 1'b0;
			latched_q  <= ST_OK;
		end else if (load_out) begin
			if (chk.last) begin
				prev_end_q <= '0;
				seen_q     <= 1'b0;
				latched_q  <= ST_OK;
			end else begin
				latched_q <= status_d;
				if (latched_q == ST_OK && status_d == ST_OK) begin
					prev_end_q <= chk.entry_end;
					seen_q     <= 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chk_ready) begin
			out_valid_q <= chk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_d;
			last_q   <= chk.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, status_q};
	assign m_axis_tlast  = last_q;

	// A closing entry leaves clean state for the next directory
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && chk.last) |=> (latched_q == ST_OK && !seen_q && prev_end_q == '0))
		else $error("directory state not cleared after last entry");

	// A latched error holds until the directory closes
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(latched_q != ST_OK && !(load_out && chk.last)) |=> $stable(latched_q))
		else $error("latched error changed inside a directory");

	// The reported status carries the latched error once one is set
	a_status_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && latched_q != ST_OK) |=> (status_q == $past(latched_q)))
		else $error("result status differs from latched error");

	// A ready result stage always lets the check stage drain
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && chk_valid) |=> out_valid_q)
		else $error("check result not moved into empty result stage");

endmodule
`default_nettype wire
